// ===== hdl/gda_pkg.sv =====
// shared types, constants, calendar functions and microcode table for the date counter
package gda_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    // datapath operations selected by the control word
    typedef enum logic [2:0] {
        OP_NOP,
        OP_FETCH,
        OP_QUOT,
        OP_MOD_STEP,
        OP_LOAD_CHECK,
        OP_ADV_STEP,
        OP_EMIT
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_MODE_ADV,
        C_ADV_MORE,
        C_OUT_BUSY
    } cond_t;

    localparam int PC_BITS = 3;
    typedef logic [PC_BITS-1:0] pc_t;

    // microprogram addresses
    localparam pc_t A_FETCH    = 3'd0;
    localparam pc_t A_DISPATCH = 3'd1;
    localparam pc_t A_QUOT     = 3'd2;
    localparam pc_t A_MOD      = 3'd3;
    localparam pc_t A_CHECK    = 3'd4;
    localparam pc_t A_ADV      = 3'd5;
    localparam pc_t A_WAIT     = 3'd6;
    localparam pc_t A_EMIT     = 3'd7;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    // condition flags reported by the datapath
    typedef struct packed {
        logic take;
        logic mode_adv;
        logic adv_more;
        logic out_busy;
    } flags_t;

    // calendar constants
    localparam logic [15:0] BASE_YEAR     = 16'd1970;
    localparam logic [8:0]  BASE_MOD400   = 9'd370;
    localparam logic [8:0]  LAST_IN_CYCLE = 9'd399;
    localparam logic [8:0]  CENT_1        = 9'd100;
    localparam logic [8:0]  CENT_2        = 9'd200;
    localparam logic [8:0]  CENT_3        = 9'd300;
    localparam logic [3:0]  JANUARY       = 4'd1;
    localparam logic [3:0]  FEBRUARY      = 4'd2;
    localparam logic [3:0]  DECEMBER      = 4'd12;
    localparam logic [4:0]  FIRST_DAY     = 5'd1;
    localparam logic [4:0]  LAST_DEC_DAY  = 5'd31;
    localparam logic [4:0]  FEB_SHORT     = 5'd28;
    localparam logic [4:0]  FEB_LONG      = 5'd29;

    // leap test on a year already reduced modulo 400
    function automatic logic leap_of(input logic [8:0] r);
        return (r[1:0] == 2'b00) && (r != CENT_1) && (r != CENT_2) && (r != CENT_3);
    endfunction

    // month length, zero for a month code outside 1..12
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic lp);
        logic [4:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            FEBRUARY:                                   len = lp ? FEB_LONG : FEB_SHORT;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // microcode rom
    function automatic ctrl_t rom(input pc_t pc);
        ctrl_t w;
        unique case (pc)
            A_FETCH:    w = '{op: OP_FETCH,      cond: C_NO_REQ,    target: A_FETCH};
            A_DISPATCH: w = '{op: OP_NOP,        cond: C_MODE_ADV,  target: A_ADV};
            A_QUOT:     w = '{op: OP_QUOT,       cond: C_NEVER,     target: A_MOD};
            A_MOD:      w = '{op: OP_MOD_STEP,   cond: C_NEVER,     target: A_CHECK};
            A_CHECK:    w = '{op: OP_LOAD_CHECK, cond: C_ALWAYS,    target: A_WAIT};
            A_ADV:      w = '{op: OP_ADV_STEP,   cond: C_ADV_MORE,  target: A_ADV};
            A_WAIT:     w = '{op: OP_NOP,        cond: C_OUT_BUSY,  target: A_WAIT};
            A_EMIT:     w = '{op: OP_EMIT,       cond: C_ALWAYS,    target: A_FETCH};
            default:    w = '{op: OP_NOP,        cond: C_ALWAYS,    target: A_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/gda_seq.sv =====
// microcode sequencer: step counter, rom lookup and conditional jumps
module gda_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  gda_pkg::flags_t flags,
    output gda_pkg::ctrl_t  ctrl
);

    gda_pkg::pc_t pc_reg;
    gda_pkg::pc_t pc_next;
    logic         jump;

    // current control word
    assign ctrl = gda_pkg::rom(pc_reg);

    // jump condition decode
    always_comb begin
        unique case (ctrl.cond)
            gda_pkg::C_NEVER:     jump = 1'b0;
            gda_pkg::C_ALWAYS:    jump = 1'b1;
            gda_pkg::C_NO_REQ:    jump = !flags.take;
            gda_pkg::C_MODE_ADV:  jump = flags.mode_adv;
            gda_pkg::C_ADV_MORE:  jump = flags.adv_more;
            gda_pkg::C_OUT_BUSY:  jump = flags.out_busy;
            default:              jump = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        if (jump) begin
            pc_next = ctrl.target;
        end else begin
            pc_next = pc_reg + gda_pkg::pc_t'(1);
        end
    end

    // step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= gda_pkg::A_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== hdl/gda_dp.sv =====
// date counter datapath: date registers, mod-400 reducer, month stepper, output register
module gda_dp #(
    parameter int YEAR_BITS = 16,
    parameter int DAYS_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gda_pkg::ctrl_t        ctrl,
    output gda_pkg::flags_t       flags,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic [1:0]            m_tuser
);

    localparam int LW = (DAYS_BITS > 5) ? DAYS_BITS : 5;
    localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;
    // ceil(2^33 / 25): exact quotient by 25 for any dividend below 2^30
    localparam logic [56:0] DIV25_MUL = 57'd343597384;

    // stored date and its year modulo 400
    logic [YEAR_BITS-1:0] year_reg, year_next;
    logic [3:0]           month_reg, month_next;
    logic [4:0]           day_reg, day_next;
    logic [8:0]           r400_reg, r400_next;

    // latched request
    logic                 mode_reg, mode_next;
    logic [YEAR_BITS-1:0] ld_year_reg, ld_year_next;
    logic [3:0]           ld_month_reg, ld_month_next;
    logic [4:0]           ld_day_reg, ld_day_next;
    logic [DAYS_BITS-1:0] left_reg, left_next;
    logic [8:0]           rem_reg, rem_next;
    logic [23:0]          q_reg, q_next;
    gda_pkg::status_t     stat_reg, stat_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          m_data_reg, m_data_next;
    gda_pkg::status_t     m_user_reg, m_user_next;

    logic                 take;
    logic [31:0]          y_ext;
    logic [27:0]          y_hi, y_rem25;
    logic [56:0]          q_prod;
    logic [4:0]           len_cur, room, len_ld;
    logic [LW-1:0]        left_ext, room_ext;
    logic                 last_year_end, adv_done, load_ok;

    assign s_tready = (ctrl.op == gda_pkg::OP_FETCH);
    assign take     = s_tvalid && s_tready;

    // year mod 400 as (year / 16 mod 25) * 16 + year mod 16
    assign y_ext   = 32'(ld_year_reg);
    assign y_hi    = y_ext[31:4];
    assign q_prod  = 57'(y_hi) * DIV25_MUL;
    assign y_rem25 = y_hi - 28'(q_reg) * 28'd25;

    // load validation
    assign len_ld  = gda_pkg::days_in(ld_month_reg, gda_pkg::leap_of(rem_reg));
    assign load_ok = (ld_day_reg != 5'd0) && (ld_day_reg <= len_ld);

    // month step terms
    assign len_cur       = gda_pkg::days_in(month_reg, gda_pkg::leap_of(r400_reg));
    assign room          = len_cur - day_reg;
    assign left_ext      = LW'(left_reg);
    assign room_ext      = LW'(room);
    assign last_year_end = (month_reg == gda_pkg::DECEMBER) && (year_reg == YEAR_MAX);
    assign adv_done      = (left_reg == '0) || (left_ext <= room_ext) || last_year_end;

    // flags to the sequencer
    assign flags.take      = take;
    assign flags.mode_adv  = mode_reg;
    assign flags.adv_more  = !adv_done;
    assign flags.out_busy  = m_valid_reg && !m_tready;

    // datapath operation
    always_comb begin
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        r400_next     = r400_reg;
        mode_next     = mode_reg;
        ld_year_next  = ld_year_reg;
        ld_month_next = ld_month_reg;
        ld_day_next   = ld_day_reg;
        left_next     = left_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        stat_next     = stat_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        unique case (ctrl.op)
            gda_pkg::OP_FETCH: begin
                if (take) begin
                    mode_next     = s_tuser;
                    ld_year_next  = YEAR_BITS'(s_tdata[15:0]);
                    ld_month_next = s_tdata[19:16];
                    ld_day_next   = s_tdata[24:20];
                    left_next     = DAYS_BITS'(s_tdata[36:25]);
                    stat_next     = gda_pkg::ST_OK;
                end
            end
            gda_pkg::OP_QUOT: begin
                q_next = q_prod[56:33];
            end
            gda_pkg::OP_MOD_STEP: begin
                rem_next = {y_rem25[4:0], y_ext[3:0]};
            end
            gda_pkg::OP_LOAD_CHECK: begin
                if (load_ok) begin
                    year_next  = ld_year_reg;
                    month_next = ld_month_reg;
                    day_next   = ld_day_reg;
                    r400_next  = rem_reg;
                end else begin
                    stat_next = gda_pkg::ST_INVALID;
                end
            end
            gda_pkg::OP_ADV_STEP: begin
                if (left_reg == '0) begin
                    left_next = left_reg;
                end else if (left_ext <= room_ext) begin
                    day_next  = day_reg + 5'(left_reg);
                    left_next = '0;
                end else if (last_year_end) begin
                    day_next  = gda_pkg::LAST_DEC_DAY;
                    stat_next = gda_pkg::ST_OVERFLOW;
                    left_next = '0;
                end else begin
                    left_next = DAYS_BITS'(left_ext - room_ext - LW'(1));
                    day_next  = gda_pkg::FIRST_DAY;
                    if (month_reg == gda_pkg::DECEMBER) begin
                        month_next = gda_pkg::JANUARY;
                        year_next  = year_reg + YEAR_BITS'(1);
                        r400_next  = (r400_reg == gda_pkg::LAST_IN_CYCLE) ? 9'd0
                                                                           : r400_reg + 9'd1;
                    end else begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            gda_pkg::OP_EMIT: begin
                m_valid_next = 1'b1;
                m_data_next  = {7'd0, day_reg, month_reg, 16'(year_reg)};
                m_user_next  = stat_reg;
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg    <= YEAR_BITS'(gda_pkg::BASE_YEAR);
            month_reg   <= gda_pkg::JANUARY;
            day_reg     <= gda_pkg::FIRST_DAY;
            r400_reg    <= gda_pkg::BASE_MOD400;
            m_valid_reg <= 1'b0;
        end else begin
            year_reg    <= year_next;
            month_reg   <= month_next;
            day_reg     <= day_next;
            r400_reg    <= r400_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        ld_year_reg  <= ld_year_next;
        ld_month_reg <= ld_month_next;
        ld_day_reg   <= ld_day_next;
        left_reg     <= left_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        stat_reg     <= stat_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hdl/gregorian_date_advance.sv =====
// top level of the gregorian date counter: sequencer plus datapath
// a load request goes from acceptance to result valid through dispatch, a two-step
// mod-400 reduction of the year, check, output wait and emit
// an advance request goes through dispatch, month steps (one month per cycle) until the
// days are used up or the year range ends, output wait and emit; both wait while a prior result is stalled
// one request at a time: s_tready rises together with m_tvalid when the result is registered
// reset (aresetn low, synchronous) gives 1970-01-01 and an empty output
module gregorian_date_advance #(
    parameter int YEAR_BITS = 16,
    parameter int DAYS_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // load_year[15:0], load_month[19:16], load_day[24:20],
                                   // advance_days[36:25], zero fill
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cur_year_out[15:0], cur_month_out[19:16],
                                   // cur_day_out[24:20], zero fill
    output logic [1:0]  m_tuser    // status
);

    gda_pkg::ctrl_t  ctrl;
    gda_pkg::flags_t flags;

    // microcode sequencer
    gda_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // datapath
    gda_dp #(
        .YEAR_BITS (YEAR_BITS),
        .DAYS_BITS (DAYS_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .flags    (flags),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/gda_checker.sv =====
// port-level checker for the date counter and its bind
module gda_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // every result has a month in 1..12, a nonzero day and a defined status
    a_date_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:16] != 4'd0) && (m_tdata[19:16] <= 4'd12)
                     && (m_tdata[24:20] != 5'd0) && (m_tuser != 2'd3))
        else $error("result date or status out of range");

    // an accepted request never yields a result in the very next cycle
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

endmodule

bind gregorian_date_advance gda_checker u_gda_checker (.*);
